[sv/i2cbs_pkg.sv]
// Shared types, codes and microcode program for the I2C master bit sequencer.
// Used by the microcode ROM, phase timer and top level; depends on nothing.
package i2cbs_pkg;

	// Bus command codes carried in func.
	localparam logic [2:0] FUNC_START    = 3'd0;
	localparam logic [2:0] FUNC_STOP     = 3'd1;
	localparam logic [2:0] FUNC_SEND     = 3'd2;
	localparam logic [2:0] FUNC_RECV     = 3'd3;
	localparam logic [2:0] FUNC_SEND_ACK = 3'd4;
	localparam logic [2:0] FUNC_RECV_ACK = 3'd5;

	// Micro-operation codes.
	localparam logic [1:0] OP_SCL    = 2'd0;
	localparam logic [1:0] OP_SDA    = 2'd1;
	localparam logic [1:0] OP_SAMPLE = 2'd2;

	// Sources of the level written by a drive operation.
	localparam logic [1:0] SRC_ZERO = 2'd0;
	localparam logic [1:0] SRC_ONE  = 2'd1;
	localparam logic [1:0] SRC_DATA = 2'd2;
	localparam logic [1:0] SRC_ACK  = 2'd3;

	localparam int unsigned PC_W      = 5;
	localparam int unsigned TICKS_W   = 16;
	localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd500;

	typedef logic [PC_W-1:0] pc_t;

	// One control word per phase.
	typedef struct packed {
		logic [1:0] op;
		logic [1:0] src;
		logic       fin;    // command ends here unless the bit loop continues
		logic       loop;   // repeat from target until eight bits are done
		logic       rv;     // present the received value on the final phase
		pc_t        target;
	} ucw_t;

	// Program entry points.
	localparam pc_t PC_START    = 5'd0;
	localparam pc_t PC_STOP     = 5'd4;
	localparam pc_t PC_SEND     = 5'd7;
	localparam pc_t PC_RECV     = 5'd10;
	localparam pc_t PC_RECV_BIT = 5'd11;
	localparam pc_t PC_SEND_ACK = 5'd14;
	localparam pc_t PC_RECV_ACK = 5'd17;

	function automatic ucw_t mk_ucw(logic [1:0] op, logic [1:0] src, logic fin,
		logic loop, logic rv, pc_t target);
		ucw_t w;
		w.op     = op;
		w.src    = src;
		w.fin    = fin;
		w.loop   = loop;
		w.rv     = rv;
		w.target = target;
		return w;
	endfunction

	// The control program: one word per pin phase.
	function automatic ucw_t ucode(pc_t pc);
		ucw_t w;
		unique case (pc)
			// Start condition.
			5'd0:  w = mk_ucw(OP_SDA, SRC_ONE, 1'b0, 1'b0, 1'b0, PC_START);
			5'd1:  w = mk_ucw(OP_SCL, SRC_ONE, 1'b0, 1'b0, 1'b0, PC_START);
			5'd2:  w = mk_ucw(OP_SDA, SRC_ZERO, 1'b0, 1'b0, 1'b0, PC_START);
			5'd3:  w = mk_ucw(OP_SCL, SRC_ZERO, 1'b1, 1'b0, 1'b0, PC_START);
			// Stop condition.
			5'd4:  w = mk_ucw(OP_SDA, SRC_ZERO, 1'b0, 1'b0, 1'b0, PC_START);
			5'd5:  w = mk_ucw(OP_SCL, SRC_ONE, 1'b0, 1'b0, 1'b0, PC_START);
			5'd6:  w = mk_ucw(OP_SDA, SRC_ONE, 1'b1, 1'b0, 1'b0, PC_START);
			// Send byte, one bit per pass.
			5'd7:  w = mk_ucw(OP_SDA, SRC_DATA, 1'b0, 1'b0, 1'b0, PC_START);
			5'd8:  w = mk_ucw(OP_SCL, SRC_ONE, 1'b0, 1'b0, 1'b0, PC_START);
			5'd9:  w = mk_ucw(OP_SCL, SRC_ZERO, 1'b1, 1'b1, 1'b0, PC_SEND);
			// Receive byte: release SDA, then sample eight bits.
			5'd10: w = mk_ucw(OP_SDA, SRC_ONE, 1'b0, 1'b0, 1'b0, PC_START);
			5'd11: w = mk_ucw(OP_SCL, SRC_ONE, 1'b0, 1'b0, 1'b0, PC_START);
			5'd12: w = mk_ucw(OP_SAMPLE, SRC_ZERO, 1'b0, 1'b0, 1'b0, PC_START);
			5'd13: w = mk_ucw(OP_SCL, SRC_ZERO, 1'b1, 1'b1, 1'b1, PC_RECV_BIT);
			// Send acknowledge.
			5'd14: w = mk_ucw(OP_SDA, SRC_ACK, 1'b0, 1'b0, 1'b0, PC_START);
			5'd15: w = mk_ucw(OP_SCL, SRC_ONE, 1'b0, 1'b0, 1'b0, PC_START);
			5'd16: w = mk_ucw(OP_SCL, SRC_ZERO, 1'b1, 1'b0, 1'b0, PC_START);
			// Receive acknowledge.
			5'd17: w = mk_ucw(OP_SDA, SRC_ONE, 1'b0, 1'b0, 1'b0, PC_START);
			5'd18: w = mk_ucw(OP_SCL, SRC_ONE, 1'b0, 1'b0, 1'b0, PC_START);
			5'd19: w = mk_ucw(OP_SAMPLE, SRC_ZERO, 1'b0, 1'b0, 1'b0, PC_START);
			5'd20: w = mk_ucw(OP_SCL, SRC_ZERO, 1'b1, 1'b0, 1'b1, PC_START);
			default: w = mk_ucw(OP_SAMPLE, SRC_ZERO, 1'b1, 1'b0, 1'b0, PC_START);
		endcase
		return w;
	endfunction

	// Entry point of each command.
	function automatic pc_t entry_pc(logic [2:0] func);
		pc_t pc;
		unique case (func)
			FUNC_START:    pc = PC_START;
			FUNC_STOP:     pc = PC_STOP;
			FUNC_SEND:     pc = PC_SEND;
			FUNC_RECV:     pc = PC_RECV;
			FUNC_SEND_ACK: pc = PC_SEND_ACK;
			FUNC_RECV_ACK: pc = PC_RECV_ACK;
			default:       pc = PC_START;
		endcase
		return pc;
	endfunction

endpackage

[sv/i2cbs_ucode_rom.sv]
// Microcode ROM of the I2C master bit sequencer, registered read.
// Depends on i2cbs_pkg for the control word type and program contents.
module i2cbs_ucode_rom (
	input  logic              clk,
	input  i2cbs_pkg::pc_t    pc,
	output i2cbs_pkg::ucw_t   cw
);
	import i2cbs_pkg::*;

	ucw_t cw_q;

	// The word for the next program counter is fetched into a register, so it is ready when that counter takes effect.
	always_ff @(posedge clk) begin
		cw_q <= ucode(pc);
	end

	assign cw = cw_q;

endmodule

[sv/i2cbs_phase_timer.sv]
// Phase hold timer: counts the cycles one pin phase is held on the bus.
// Depends on i2cbs_pkg for the tick width.
module i2cbs_phase_timer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  logic [i2cbs_pkg::TICKS_W-1:0]    ticks,
	output logic                             done
);
	import i2cbs_pkg::*;

	logic [TICKS_W-1:0] cnt_q;

	// A phase of zero ticks is held like a phase of one tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= (ticks == '0) ? '0 : ticks - TICKS_W'(1);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - TICKS_W'(1);
		end
	end

	assign done = (cnt_q == '0);

endmodule

[sv/i2c_master_bit_sequencer_top.sv]
// I2C master bit sequencer: each valid command yields 3 to 25 pin phases, one transfer per phase.
// The first phase issues once the command is taken, the previous phase's hold has run out and
// the output register is free; each later phase issues once the phase timer has run out the
// hold of the one before it (phase_ticks, where zero acts as one), later only while that phase
// still waits in the output register. The next command is taken from the cycle after the
// final phase enters the output register. Reset is asynchronous: pins released, 500 ticks.
module i2c_master_bit_sequencer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [i2cbs_pkg::TICKS_W-1:0]  cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [2:0]                     func,
	input  logic [7:0]                     data_byte,
	input  logic                           ack_bit,
	input  logic [7:0]                     line_levels,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           scl,
	output logic                           sda,
	output logic                           is_sample,
	output logic [7:0]                     read_value,
	output logic                           last
);
	import i2cbs_pkg::*;

	logic [TICKS_W-1:0] phase_ticks_q;
	logic               busy_q;
	pc_t                pc_q;
	pc_t                pc_next;
	logic [2:0]         bitcnt_q;
	logic [7:0]         data_q;
	logic [7:0]         lines_q;
	logic               ack_q;
	logic [7:0]         got_q;
	logic               scl_q;
	logic               sda_q;
	logic               out_valid_q;
	logic               is_sample_q;
	logic [7:0]         read_value_q;
	logic               last_q;
	ucw_t               cw;
	logic               tmr_done;
	logic               in_xfer;
	logic               cmd_ok;
	logic               issue;
	logic               src_lvl;
	logic               scl_n;
	logic               sda_n;
	logic               loop_more;
	logic               last_n;

	assign in_ready = !busy_q;
	assign in_xfer  = in_valid && in_ready;
	assign cmd_ok   = (func <= FUNC_RECV_ACK);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= TICKS_RESET;
		end else if (cfg_we) begin
			phase_ticks_q <= cfg_wdata;
		end
	end

	// A phase issues once the previous phase has run out and the output register is free.
	// The ROM word always matches pc_q, since it is fetched from pc_next.
	assign issue = busy_q && tmr_done && (!out_valid_q || out_ready);

	// Level written by the current word.
	always_comb begin
		case (cw.src)
			SRC_ZERO: src_lvl = 1'b0;
			SRC_ONE:  src_lvl = 1'b1;
			SRC_DATA: src_lvl = data_q[7];
			SRC_ACK:  src_lvl = ack_q;
			default:  src_lvl = 1'b0;
		endcase
	end

	// Pin level update decoder.
	always_comb begin
		scl_n = scl_q;
		sda_n = sda_q;
		unique case (cw.op)
			OP_SCL:    scl_n = src_lvl;
			OP_SDA:    sda_n = src_lvl;
			OP_SAMPLE: ;
			default:   ;
		endcase
	end

	assign loop_more = cw.loop && (bitcnt_q != 3'd7);
	assign last_n    = cw.fin && !loop_more;

	// Next program counter: command entry point on a transfer, jump back for another bit, or step on.
	always_comb begin
		if (in_xfer) begin
			pc_next = entry_pc(func);
		end else if (issue && loop_more) begin
			pc_next = cw.target;
		end else if (issue) begin
			pc_next = pc_q + PC_W'(1);
		end else begin
			pc_next = pc_q;
		end
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			pc_q     <= PC_START;
			bitcnt_q <= '0;
			scl_q    <= 1'b1;
			sda_q    <= 1'b1;
		end else begin
			pc_q <= pc_next;
			if (in_xfer) begin
				busy_q   <= cmd_ok;
				bitcnt_q <= '0;
			end else if (issue) begin
				scl_q <= scl_n;
				sda_q <= sda_n;
				if (loop_more) begin
					bitcnt_q <= bitcnt_q + 3'd1;
				end
				if (last_n) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Command operands: transmit and line-level shifters, received byte.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			data_q  <= data_byte;
			lines_q <= line_levels;
			ack_q   <= ack_bit;
			got_q   <= '0;
		end else if (issue) begin
			if (cw.op == OP_SDA && cw.src == SRC_DATA) begin
				data_q <= {data_q[6:0], 1'b0};
			end
			if (cw.op == OP_SAMPLE) begin
				got_q   <= {got_q[6:0], lines_q[7]};
				lines_q <= {lines_q[6:0], 1'b0};
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (issue) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (issue) begin
			is_sample_q  <= (cw.op == OP_SAMPLE);
			read_value_q <= (cw.rv && last_n) ? got_q : 8'd0;
			last_q       <= last_n;
		end
	end

	i2cbs_ucode_rom u_rom (
		.clk (clk),
		.pc  (pc_next),
		.cw  (cw)
	);

	i2cbs_phase_timer u_tmr (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (issue),
		.ticks  (phase_ticks_q),
		.done   (tmr_done)
	);

	assign out_valid  = out_valid_q;
	assign scl        = scl_q;
	assign sda        = sda_q;
	assign is_sample  = is_sample_q;
	assign read_value = read_value_q;
	assign last       = last_q;

endmodule

[sv/i2cbs_checker.sv]
// Port-level checker for the I2C master bit sequencer, bound to the top level.
// Depends only on the top level's ports.
module i2cbs_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       scl,
	input  logic       sda,
	input  logic       is_sample,
	input  logic [7:0] read_value,
	input  logic       last
);

	// A stalled phase keeps its pin levels.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(scl) && $stable(sda))
		else $error("stalled phase changed");

	// A sample phase is never the final phase of a command.
	a_sample_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_sample |-> !last)
		else $error("sample phase marked last");

	// SDA is only sampled while SCL is released high.
	a_sample_scl_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_sample |-> scl)
		else $error("sample with SCL low");

	// A received value appears only on a final phase.
	a_value_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_value != 8'd0 |-> last)
		else $error("read value outside final phase");

endmodule

bind i2c_master_bit_sequencer_top i2cbs_checker u_chk (.*);
